>>> sv/svm_pkg.sv
package svm_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAL_GAIN   = 3'd0,
		REG_CAL_OFFSET = 3'd1,
		REG_BAT_MIN    = 3'd2,
		REG_BAT_MAX    = 3'd3,
		REG_USB_MIN    = 3'd4,
		REG_USB_MAX    = 3'd5
	} cfg_reg_t;

	// reset values of the configuration registers
	localparam logic [23:0]        CAL_GAIN_RST   = 24'd65536;
	localparam logic signed [15:0] CAL_OFFSET_RST = 16'sd0;
	localparam logic [15:0]        BAT_MIN_RST    = 16'd3300;
	localparam logic [15:0]        BAT_MAX_RST    = 16'd4200;
	localparam logic [15:0]        USB_MIN_RST    = 16'd4500;
	localparam logic [15:0]        USB_MAX_RST    = 16'd5500;

	// calibration settings used by the front end
	typedef struct packed {
		logic [23:0]        gain;
		logic signed [15:0] offset_mv;
	} cal_cfg_t;

	// classification windows used by the back end
	typedef struct packed {
		logic [15:0] bat_min_mv;
		logic [15:0] bat_max_mv;
		logic [15:0] usb_min_mv;
		logic [15:0] usb_max_mv;
	} win_cfg_t;

	// source classes
	typedef enum logic [1:0] {
		SRC_UNKNOWN = 2'd0,
		SRC_BATTERY = 2'd1,
		SRC_USB     = 2'd2
	} src_type_t;

	// how the percent output is formed
	typedef enum logic [1:0] {
		PCT_NONE  = 2'd0,
		PCT_EMPTY = 2'd1,
		PCT_FULL  = 2'd2,
		PCT_ROM   = 2'd3
	} pct_sel_t;

	localparam logic signed [7:0] PCT_NONE_VAL  = -8'sd1;
	localparam logic signed [7:0] PCT_EMPTY_VAL = 8'sd0;
	localparam logic signed [7:0] PCT_FULL_VAL  = 8'sd100;

	// percent table span in millivolts
	localparam int PCT_LO_MV = 3500;
	localparam int PCT_HI_MV = 4190;
	localparam int PCT_ROM_DEPTH = PCT_HI_MV - PCT_LO_MV + 1;
	localparam int PCT_ROM_AW = $clog2(PCT_ROM_DEPTH);

	typedef logic signed [7:0] pct_rom_t [PCT_ROM_DEPTH];

	// quartic coefficients scaled by 1e4
	localparam longint COEF_A = 64'sd28083808;
	localparam longint COEF_B = 64'sd435609157;
	localparam longint COEF_C = 64'sd2528485888;
	localparam longint COEF_D = 64'sd6507674615;
	localparam longint COEF_E = 64'sd6265325703;
	localparam longint SC_3   = 64'sd1000;
	localparam longint SC_6   = 64'sd1000000;
	localparam longint SC_9   = 64'sd1000000000;
	localparam longint HALF_10 = 64'sd5000000000;
	localparam longint SC_10  = 64'sd10000000000;

	// exact quartic percent, rounded half up toward zero truncation
	function automatic logic signed [7:0] quartic_pct(input int mv);
		longint m;
		longint t1;
		longint t2;
		longint t3;
		longint hi;
		longint lo;
		longint x;
		longint lm;
		longint y;
		longint z;
		longint res;
		logic frac;
		m = longint'(mv);
		t1 = COEF_A * m - COEF_B * SC_3;
		t2 = t1 * m + COEF_C * SC_6;
		t3 = t2 * m - COEF_D * SC_9;
		hi = t3 / SC_6;
		lo = t3 - hi * SC_6;
		if (lo < 0) begin
			lo = lo + SC_6;
			hi = hi - 1;
		end
		x = hi * m + COEF_E * SC_6;
		lm = lo * m;
		y = x + lm / SC_6;
		frac = ((lm % SC_6) != 0);
		z = y + HALF_10;
		if (z >= 0) begin
			res = z / SC_10;
		end else if (frac) begin
			res = -((-z - 1) / SC_10);
		end else begin
			res = -((-z) / SC_10);
		end
		if (res > 127) begin
			res = 127;
		end
		if (res < -128) begin
			res = -128;
		end
		return res[7:0];
	endfunction

	// percent table filled at elaboration
	function automatic pct_rom_t build_pct_rom();
		pct_rom_t r;
		for (int i = 0; i < PCT_ROM_DEPTH; i++) begin
			r[i] = quartic_pct(PCT_LO_MV + i);
		end
		return r;
	endfunction

endpackage

>>> sv/svm_front.sv
module svm_front
	import svm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cal_cfg_t    cal,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [11:0] adc_sample,
	output logic        push,
	input  logic        queue_full,
	output logic [15:0] mv
);

	logic               valid_s1;
	logic [15:0]        mv_s1;
	logic [35:0]        prod;
	logic signed [21:0] sum;
	logic [15:0]        mv_sat;
	logic               advance;

	// calibration line: scale, truncate, add offset, saturate
	always_comb begin
		prod = {12'd0, cal.gain} * {24'd0, adc_sample};
		sum = $signed({2'b00, prod[35:16]}) + 22'(cal.offset_mv);
		if (sum < 0) begin
			mv_sat = 16'd0;
		end else if (sum > 22'sd65535) begin
			mv_sat = 16'hFFFF;
		end else begin
			mv_sat = sum[15:0];
		end
	end

	// stage register ahead of the queue
	assign push = valid_s1 && !queue_full;
	assign advance = !valid_s1 || push;
	assign in_stall = !advance;
	assign mv = mv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			mv_s1 <= mv_sat;
		end
	end

endmodule

>>> sv/svm_queue.sv
module svm_queue #(
	parameter int DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [15:0] push_data,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output logic [15:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [15:0]      mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/svm_back.sv
module svm_back
	import svm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  win_cfg_t          win,
	input  logic              queue_empty,
	input  logic [15:0]       mv,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       avg_mv,
	output logic [1:0]        source_type,
	output logic              out_of_range,
	output logic signed [7:0] battery_percent
);

	localparam pct_rom_t PCT_TABLE = build_pct_rom();

	logic                  seeded_q;
	logic [15:0]           avg_q;
	logic                  valid_s1;
	logic [15:0]           avg_s1;
	src_type_t             type_s1;
	logic                  oor_s1;
	pct_sel_t              sel_s1;
	logic signed [7:0]     rom_s1;
	logic                  take;
	logic [16:0]           pair_sum;
	logic [15:0]           avg_next;
	src_type_t             type_next;
	logic                  oor_next;
	pct_sel_t              sel_next;
	logic [15:0]           rom_off;
	logic [PCT_ROM_AW-1:0] rom_addr;

	assign take = !valid_s1 || !out_stall;
	assign pop = take && !queue_empty;

	// running average: mean of the previous average and the new sample, seeded by the first sample
	always_comb begin
		pair_sum = {1'b0, avg_q} + {1'b0, mv};
		avg_next = seeded_q ? pair_sum[16:1] : mv;
	end

	// classify and pick the percent source
	always_comb begin
		if (avg_next >= win.bat_min_mv && avg_next <= win.bat_max_mv) begin
			type_next = SRC_BATTERY;
		end else if (avg_next >= win.usb_min_mv && avg_next <= win.usb_max_mv) begin
			type_next = SRC_USB;
		end else begin
			type_next = SRC_UNKNOWN;
		end
		oor_next = (avg_next < win.bat_min_mv) || (avg_next > win.usb_max_mv);
		rom_off = avg_next - 16'(PCT_LO_MV);
		rom_addr = '0;
		if (type_next != SRC_BATTERY) begin
			sel_next = PCT_NONE;
		end else if (avg_next > 16'(PCT_HI_MV)) begin
			sel_next = PCT_FULL;
		end else if (avg_next < 16'(PCT_LO_MV)) begin
			sel_next = PCT_EMPTY;
		end else begin
			sel_next = PCT_ROM;
			rom_addr = rom_off[PCT_ROM_AW-1:0];
		end
	end

	// average state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			avg_q <= 16'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (pop) begin
				seeded_q <= 1'b1;
				avg_q <= avg_next;
			end
			if (take) begin
				valid_s1 <= !queue_empty;
			end
		end
	end

	// result register with registered table read
	always_ff @(posedge clk) begin
		if (pop) begin
			avg_s1 <= avg_next;
			type_s1 <= type_next;
			oor_s1 <= oor_next;
			sel_s1 <= sel_next;
			rom_s1 <= PCT_TABLE[rom_addr];
		end
	end

	// percent output select
	always_comb begin
		case (sel_s1)
			PCT_NONE:  battery_percent = PCT_NONE_VAL;
			PCT_EMPTY: battery_percent = PCT_EMPTY_VAL;
			PCT_FULL:  battery_percent = PCT_FULL_VAL;
			PCT_ROM:   battery_percent = rom_s1;
			default:   battery_percent = PCT_NONE_VAL;
		endcase
	end

	assign out_valid = valid_s1;
	assign avg_mv = avg_s1;
	assign source_type = type_s1;
	assign out_of_range = oor_s1;

endmodule

>>> sv/supply_voltage_monitor.sv
// channel    direction  handshake            payload
// in         input      in_valid/in_stall    adc_sample
// out        output     out_valid/out_stall  avg_mv, source_type, out_of_range, battery_percent
// cfg        input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one sample per cycle sustained while out_stall is low; the path from input to result runs through
// the front calibration register, a queue entry and the result register with table read.
// arst_n clears the average, the seeded flag, the queue and all valid flags, and
// loads the calibration and window registers with their default values.
// out_stall holds the result register; the queue then fills and in_stall rises.
// cfg_ready is always high; configuration takes effect on the next cycle.
module supply_voltage_monitor
	import svm_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [11:0]           adc_sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [15:0]           avg_mv,
	output logic [1:0]            source_type,
	output logic                  out_of_range,
	output logic signed [7:0]     battery_percent,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cal_cfg_t    cal_q;
	win_cfg_t    win_q;
	logic        push;
	logic        pop;
	logic        queue_full;
	logic        queue_empty;
	logic [15:0] front_mv;
	logic [15:0] queue_mv;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.gain <= CAL_GAIN_RST;
			cal_q.offset_mv <= CAL_OFFSET_RST;
			win_q.bat_min_mv <= BAT_MIN_RST;
			win_q.bat_max_mv <= BAT_MAX_RST;
			win_q.usb_min_mv <= USB_MIN_RST;
			win_q.usb_max_mv <= USB_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAL_GAIN:   cal_q.gain <= cfg_data;
				REG_CAL_OFFSET: cal_q.offset_mv <= $signed(cfg_data[15:0]);
				REG_BAT_MIN:    win_q.bat_min_mv <= cfg_data[15:0];
				REG_BAT_MAX:    win_q.bat_max_mv <= cfg_data[15:0];
				REG_USB_MIN:    win_q.usb_min_mv <= cfg_data[15:0];
				REG_USB_MAX:    win_q.usb_max_mv <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// calibration front end
	svm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cal        (cal_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.adc_sample (adc_sample),
		.push       (push),
		.queue_full (queue_full),
		.mv         (front_mv)
	);

	// decoupling queue
	svm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_mv),
		.full      (queue_full),
		.pop       (pop),
		.empty     (queue_empty),
		.pop_data  (queue_mv)
	);

	// averaging, classification and percent back end
	svm_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.win             (win_q),
		.queue_empty     (queue_empty),
		.mv              (queue_mv),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.avg_mv          (avg_mv),
		.source_type     (source_type),
		.out_of_range    (out_of_range),
		.battery_percent (battery_percent)
	);

endmodule
